// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the journal allocator RTL.
// Needs nothing else; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define CJAL_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("cjal assertion failed");

// checked at every edge, reset included
`define CJAL_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("cjal assertion failed (always)");

`endif

// ----- hdl/cjal_pkg.sv -----
// Types and codes of the circular journal allocator.
// No dependencies; used by scoped names from the RTL.
`timescale 1ns / 1ps
package cjal_pkg;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_CHECK, S_OVR, S_RD, S_EV, S_ZAP, S_FILL, S_FIN
  } state_e;

  typedef enum logic [1:0] {
    W_TAIL, W_HEAD, W_TAIL2
  } walk_e;

  typedef enum logic [1:0] {
    PK_EMPTY = 2'd0,
    PK_HDR   = 2'd1,
    PK_PAD   = 2'd2,
    PK_DATA  = 2'd3
  } page_kind_e;

  typedef enum logic [1:0] {
    K_EVICT = 2'd0,
    K_DONE  = 2'd1,
    K_BIG   = 2'd2,
    K_RSVD  = 2'd3
  } res_kind_e;

  localparam int unsigned MaxResults = 62;
  localparam int unsigned LenW       = 5;
  localparam int unsigned EntryW     = LenW + 2;
  localparam int unsigned MinRing    = 32;

  localparam logic [2:0] RegBase  = 3'd0;
  localparam logic [2:0] RegPages = 3'd4;

endpackage

// ----- hdl/cjal_ram.sv -----
// Page descriptor store: one write port, one registered read port.
// Depends on nothing.
`timescale 1ns / 1ps
module cjal_ram #(
  parameter int unsigned Depth = 4096,
  parameter int unsigned AddrW = 12,
  parameter int unsigned DataW = 7
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem [Depth];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/circular_journal_allocator_unit.sv -----
// Circular journal allocator top level: sequencer, config registers, result register.
// Depends on cjal_pkg, cjal_ram and assert_macros.svh.
`timescale 1ns / 1ps
// After reset the block sweeps the page store once before it takes a request. One
// request then holds the input off until its final result has been handed to the
// output register. The time is set by the page store: an eviction walk reads and
// then examines each page it visits, each page under an evicted record is cleared,
// and each page of the pad and the new record is written, with a setup check before
// and a finish step after.
`include "assert_macros.svh"
module circular_journal_allocator_unit #(
  parameter int unsigned RING_PAGES     = 4096,
  parameter int unsigned MAX_DATA_PAGES = 30
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [4:0] data_pages
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [119:0] m_axis_tdata,   // evict_page, evict_len, header_page, pad_hdr_page, pad_len
  output logic [2:0]   m_axis_tuser,   // kind, pad_valid
  output logic         m_axis_tlast,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int unsigned AW = $clog2(RING_PAGES);
  localparam int unsigned OW = AW + 1;
  localparam int unsigned LW = cjal_pkg::LenW;

  cjal_pkg::state_e state_q, state_d;
  cjal_pkg::walk_e  walk_q, walk_d;

  logic [31:0]   base_q, base_d;
  logic [12:0]   pages_q, pages_d;
  logic [OW-1:0] cur_q, cur_d, lim_q, lim_d, l_q, l_d, nf_q, nf_d;
  logic [OW-1:0] hdr_q, hdr_d, poff_q, poff_d;
  logic [LW-1:0] n_q, n_d, zrem_q, zrem_d, d_q, d_d;
  logic          pv_q, pv_d, skip_q, skip_d, fpad_q, fpad_d;
  logic [5:0]    cnt_q, cnt_d;

  logic          mv_q, mv_d, ml_q, ml_d, mpv_q, mpv_d;
  logic [1:0]    mk_q, mk_d;
  logic [31:0]   mep_q, mep_d, mhp_q, mhp_d, mpp_q, mpp_d;
  logic [12:0]   mel_q, mel_d;
  logic [LW-1:0] mpl_q, mpl_d;

  logic                          we;
  logic [AW-1:0]                 waddr;
  logic [cjal_pkg::EntryW-1:0]   wdata, rdata;
  logic [1:0]                    rk;
  logic [LW-1:0]                 rlen, len_eff, pl;
  logic [OW-1:0]                 room, cur_inc, l_c, nf_c;
  logic [31:0]                   lw;
  logic                          out_free, inc_ge, treat_loop, hdr_full;
  logic                          ev_end, ev_step, ev_wait, zap_end, zap_more, fill_last;
  logic                          walk_end, cfg_we, in_acc, big;

  cjal_ram #(
    .Depth (RING_PAGES),
    .AddrW (AW),
    .DataW (cjal_pkg::EntryW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (cur_q[AW-1:0]),
    .rdata_o (rdata)
  );

  assign pready        = 1'b1;
  assign cfg_we        = psel && penable && pwrite;
  assign prdata        = paddr[2] ? {19'd0, pages_q} : base_q;
  assign s_axis_tready = (state_q == cjal_pkg::S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !mv_q || m_axis_tready;

  always_comb begin
    lw = {19'd0, pages_q};
    if (lw < 32'(cjal_pkg::MinRing)) lw = 32'(cjal_pkg::MinRing);
    if (lw > 32'(RING_PAGES)) lw = 32'(RING_PAGES);
    l_c  = lw[OW-1:0];
    nf_c = (nf_q >= l_c) ? '0 : nf_q;
    big  = (32'(d_q) > 32'(MAX_DATA_PAGES)) || ((OW'(d_q) + OW'(1)) > l_c);
  end

  // walk evaluation
  always_comb begin
    rk         = rdata[1:0];
    rlen       = rdata[cjal_pkg::EntryW-1:2];
    room       = l_q - cur_q;
    len_eff    = (rlen == '0) ? LW'(1) : rlen;
    if (OW'(len_eff) > room) len_eff = room[LW-1:0];
    cur_inc    = cur_q + OW'(1);
    inc_ge     = (cur_inc >= lim_q);
    treat_loop = !(skip_q && (rk == cjal_pkg::PK_EMPTY || rk == cjal_pkg::PK_PAD));
    hdr_full   = (cnt_q >= 6'(cjal_pkg::MaxResults - 1));
    ev_step    = !treat_loop && rk == cjal_pkg::PK_EMPTY && !inc_ge;
    ev_end     = (!treat_loop && rk == cjal_pkg::PK_EMPTY && inc_ge)
              || (!treat_loop && rk == cjal_pkg::PK_PAD)
              || (treat_loop && rk == cjal_pkg::PK_EMPTY)
              || (treat_loop && rk == cjal_pkg::PK_HDR && hdr_full);
    ev_wait    = treat_loop && rk == cjal_pkg::PK_HDR && !hdr_full && !out_free;
    zap_end    = (zrem_q == LW'(1)) && inc_ge;
    zap_more   = (zrem_q == LW'(1)) && !inc_ge;
    fill_last  = (cur_inc == lim_q);
    pl         = 5'(l_q - poff_q);
    walk_end   = (state_q == cjal_pkg::S_EV && ev_end)
              || (state_q == cjal_pkg::S_ZAP && zap_end);
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      cjal_pkg::S_CLR:   if (cur_q == OW'(RING_PAGES - 1)) state_d = cjal_pkg::S_IDLE;
      cjal_pkg::S_IDLE:  if (in_acc) state_d = cjal_pkg::S_CHECK;
      cjal_pkg::S_CHECK: state_d = big ? cjal_pkg::S_OVR : cjal_pkg::S_RD;
      cjal_pkg::S_OVR:   if (out_free) state_d = cjal_pkg::S_IDLE;
      cjal_pkg::S_RD:    state_d = cjal_pkg::S_EV;
      cjal_pkg::S_EV: begin
        if (ev_step) state_d = cjal_pkg::S_RD;
        else if (!ev_end && !ev_wait) state_d = cjal_pkg::S_ZAP;
      end
      cjal_pkg::S_ZAP:   if (zap_more) state_d = cjal_pkg::S_RD;
      cjal_pkg::S_FILL:  if (fill_last && !fpad_q) state_d = cjal_pkg::S_FIN;
      cjal_pkg::S_FIN:   if (out_free) state_d = cjal_pkg::S_IDLE;
      default:           state_d = cjal_pkg::S_IDLE;
    endcase
    if (walk_end) begin
      case (walk_q)
        cjal_pkg::W_TAIL: state_d = cjal_pkg::S_RD;
        cjal_pkg::W_HEAD: state_d = pv_q ? cjal_pkg::S_RD : cjal_pkg::S_FILL;
        default:          state_d = cjal_pkg::S_FILL;
      endcase
    end
  end

  // datapath and outputs
  always_comb begin
    base_d = base_q;  pages_d = pages_q;
    cur_d = cur_q;  lim_d = lim_q;  l_d = l_q;  nf_d = nf_q;
    hdr_d = hdr_q;  poff_d = poff_q;  n_d = n_q;  zrem_d = zrem_q;  d_d = d_q;
    pv_d = pv_q;  skip_d = skip_q;  fpad_d = fpad_q;  cnt_d = cnt_q;  walk_d = walk_q;
    mv_d = mv_q && !m_axis_tready;
    mk_d = mk_q;  ml_d = ml_q;  mpv_d = mpv_q;  mep_d = mep_q;  mhp_d = mhp_q;
    mpp_d = mpp_q;  mel_d = mel_q;  mpl_d = mpl_q;
    we = 1'b0;  waddr = cur_q[AW-1:0];  wdata = {LW'(0), cjal_pkg::PK_EMPTY};

    if (cfg_we) begin
      if (paddr[2]) pages_d = pwdata[12:0];
      else base_d = pwdata;
    end

    case (state_q)
      cjal_pkg::S_CLR: begin
        we    = 1'b1;
        cur_d = (cur_q == OW'(RING_PAGES - 1)) ? '0 : cur_inc;
      end
      cjal_pkg::S_IDLE: if (in_acc) d_d = s_axis_tdata[LW-1:0];
      cjal_pkg::S_CHECK: begin
        l_d    = l_c;
        nf_d   = nf_c;
        n_d    = d_q + LW'(1);
        cnt_d  = '0;
        skip_d = 1'b1;
        cur_d  = nf_c;
        if ((l_c - nf_c) < (OW'(d_q) + OW'(1))) begin
          pv_d   = 1'b1;
          poff_d = nf_c;
          hdr_d  = '0;
          lim_d  = l_c;
          walk_d = cjal_pkg::W_TAIL;
        end else begin
          pv_d   = 1'b0;
          hdr_d  = nf_c;
          lim_d  = nf_c + OW'(d_q) + OW'(1);
          walk_d = cjal_pkg::W_HEAD;
        end
      end
      cjal_pkg::S_OVR: if (out_free) begin
        mv_d = 1'b1;  ml_d = 1'b1;  mk_d = cjal_pkg::K_BIG;  mpv_d = 1'b0;
        mep_d = '0;  mel_d = '0;  mhp_d = '0;  mpp_d = '0;  mpl_d = '0;
      end
      cjal_pkg::S_EV: begin
        if (ev_step) begin
          cur_d = cur_inc;
        end else if (!treat_loop && rk == cjal_pkg::PK_PAD) begin
          we = 1'b1;
        end else if (!ev_end && !ev_wait) begin
          skip_d = 1'b0;
          zrem_d = (rk == cjal_pkg::PK_DATA) ? LW'(1) : len_eff;
          if (rk == cjal_pkg::PK_HDR) begin
            cnt_d = cnt_q + 6'd1;
            mv_d = 1'b1;  ml_d = 1'b0;  mk_d = cjal_pkg::K_EVICT;  mpv_d = 1'b0;
            mep_d = base_q + 32'(cur_q);  mel_d = 13'(len_eff);
            mhp_d = '0;  mpp_d = '0;  mpl_d = '0;
          end
        end
      end
      cjal_pkg::S_ZAP: begin
        we     = 1'b1;
        cur_d  = cur_inc;
        zrem_d = zrem_q - LW'(1);
      end
      cjal_pkg::S_FILL: begin
        we = 1'b1;
        if (fpad_q) begin
          wdata = (cur_q == poff_q) ? {pl, cjal_pkg::PK_PAD} : {LW'(0), cjal_pkg::PK_EMPTY};
        end else begin
          wdata = (cur_q == hdr_q) ? {n_q, cjal_pkg::PK_HDR} : {n_q, cjal_pkg::PK_DATA};
        end
        cur_d = cur_inc;
        if (fill_last && fpad_q) begin
          fpad_d = 1'b0;
          cur_d  = hdr_q;
          lim_d  = hdr_q + OW'(n_q);
        end
      end
      cjal_pkg::S_FIN: if (out_free) begin
        mv_d = 1'b1;  ml_d = 1'b1;  mk_d = cjal_pkg::K_DONE;  mpv_d = pv_q;
        mep_d = '0;  mel_d = '0;  mhp_d = base_q + 32'(hdr_q);
        mpp_d = pv_q ? base_q + 32'(poff_q) : '0;
        mpl_d = pv_q ? pl : '0;
      end
      default: ;
    endcase

    if (walk_end) begin
      skip_d = 1'b1;
      case (walk_q)
        cjal_pkg::W_TAIL: begin
          walk_d = cjal_pkg::W_HEAD;
          cur_d  = '0;
          lim_d  = OW'(n_q);
        end
        cjal_pkg::W_HEAD: begin
          nf_d = ((hdr_q + OW'(n_q)) >= l_q) ? '0 : hdr_q + OW'(n_q);
          if (pv_q) begin
            walk_d = cjal_pkg::W_TAIL2;
            cur_d  = poff_q;
            lim_d  = l_q;
          end else begin
            fpad_d = 1'b0;
            cur_d  = hdr_q;
            lim_d  = hdr_q + OW'(n_q);
          end
        end
        default: begin
          fpad_d = 1'b1;
          cur_d  = poff_q;
          lim_d  = l_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cjal_pkg::S_CLR;
      walk_q  <= cjal_pkg::W_TAIL;
      base_q  <= '0;
      pages_q <= 13'(RING_PAGES);
      cur_q   <= '0;
      nf_q    <= '0;
      mv_q    <= 1'b0;
      cnt_q   <= '0;
      skip_q  <= 1'b1;
      fpad_q  <= 1'b0;
      pv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      walk_q  <= walk_d;
      base_q  <= base_d;
      pages_q <= pages_d;
      cur_q   <= cur_d;
      nf_q    <= nf_d;
      mv_q    <= mv_d;
      cnt_q   <= cnt_d;
      skip_q  <= skip_d;
      fpad_q  <= fpad_d;
      pv_q    <= pv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lim_q  <= lim_d;   l_q   <= l_d;    hdr_q <= hdr_d;  poff_q <= poff_d;
    n_q    <= n_d;     zrem_q <= zrem_d; d_q  <= d_d;
    mk_q   <= mk_d;    ml_q  <= ml_d;   mpv_q <= mpv_d;  mep_q <= mep_d;
    mhp_q  <= mhp_d;   mpp_q <= mpp_d;  mel_q <= mel_d;  mpl_q <= mpl_d;
  end

  assign m_axis_tvalid = mv_q;
  assign m_axis_tlast  = ml_q;
  assign m_axis_tuser  = {mpv_q, mk_q};
  assign m_axis_tdata  = {6'd0, mpl_q, mpp_q, mhp_q, mel_q, mep_q};

  `CJAL_ASSERT_ALWAYS(a_reset_sweep, clk_i, !rst_ni |=> state_q == cjal_pkg::S_CLR)
  `CJAL_ASSERT(a_accept_check, clk_i, rst_ni, in_acc |=> state_q == cjal_pkg::S_CHECK)
  `CJAL_ASSERT(a_walk_in_range, clk_i, rst_ni, state_q == cjal_pkg::S_EV |-> cur_q < lim_q)
  `CJAL_ASSERT(a_result_bound, clk_i, rst_ni, cnt_q <= 6'(cjal_pkg::MaxResults - 1))

endmodule
